// ===== rtl/bchd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bchd_pkg
// shared types and constants of the button click / hold detector
// ----------------------------------------------------------------------------
package bchd_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned THR_W  = 16;
    localparam int unsigned IDX_W  = 2;
    localparam int unsigned EVT_W  = 2;

    // packed stream widths, rounded up to whole bytes
    localparam int unsigned S_TDATA_W = 40;
    localparam int unsigned M_TDATA_W = 8;

    // register indexes on the write port
    localparam logic [IDX_W-1:0] REG_CLICK_MIN   = 2'd0;
    localparam logic [IDX_W-1:0] REG_HOLD_FIRST  = 2'd1;
    localparam logic [IDX_W-1:0] REG_HOLD_REPEAT = 2'd2;

    // reset values of the thresholds
    localparam logic [THR_W-1:0] CLICK_MIN_RST   = 16'd200;
    localparam logic [THR_W-1:0] HOLD_FIRST_RST  = 16'd1500;
    localparam logic [THR_W-1:0] HOLD_REPEAT_RST = 16'd1000;

    typedef enum logic [EVT_W-1:0] {
        EV_NONE  = 2'd0,
        EV_CLICK = 2'd1,
        EV_HOLD  = 2'd2
    } event_t;

    typedef struct packed {
        logic [THR_W-1:0] click_min_ms;
        logic [THR_W-1:0] hold_first_ms;
        logic [THR_W-1:0] hold_repeat_ms;
    } cfg_t;

endpackage
`default_nettype wire

// ===== rtl/bchd_cfg_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bchd_cfg_regs
// threshold registers written through the plain write port
// ----------------------------------------------------------------------------
module bchd_cfg_regs (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_wr_en,
    input  wire logic [bchd_pkg::IDX_W-1:0]  cfg_index,
    input  wire logic [bchd_pkg::THR_W-1:0]  cfg_wdata,
    output bchd_pkg::cfg_t                   cfg
);

    bchd_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.click_min_ms   <= bchd_pkg::CLICK_MIN_RST;
            cfg_reg.hold_first_ms  <= bchd_pkg::HOLD_FIRST_RST;
            cfg_reg.hold_repeat_ms <= bchd_pkg::HOLD_REPEAT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                bchd_pkg::REG_CLICK_MIN:   cfg_reg.click_min_ms   <= cfg_wdata;
                bchd_pkg::REG_HOLD_FIRST:  cfg_reg.hold_first_ms  <= cfg_wdata;
                bchd_pkg::REG_HOLD_REPEAT: cfg_reg.hold_repeat_ms <= cfg_wdata;
                default: ; // unused index, write dropped
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

// ===== rtl/bchd_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bchd_core
// press / release / hold classifier with its tracking state
// ----------------------------------------------------------------------------
module bchd_core (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         step_en,
    input  wire logic                         pin_level,
    input  wire logic [bchd_pkg::TIME_W-1:0]  now_ms,
    input  wire bchd_pkg::cfg_t               cfg,
    output bchd_pkg::event_t                  event_res
);

    logic                        was_pressed_reg, was_pressed_next;
    logic                        repeating_reg, repeating_next;
    logic [bchd_pkg::TIME_W-1:0] mark_time_reg, mark_time_next;

    logic                        pressed;
    logic [bchd_pkg::TIME_W-1:0] elapsed;
    logic                        over_click, over_first, over_repeat;

    assign pressed = ~pin_level;
    // modular difference, wrap gives a long elapsed time
    assign elapsed = now_ms - mark_time_reg;

    assign over_click  = elapsed > {{(bchd_pkg::TIME_W-bchd_pkg::THR_W){1'b0}},
                                    cfg.click_min_ms};
    assign over_first  = elapsed > {{(bchd_pkg::TIME_W-bchd_pkg::THR_W){1'b0}},
                                    cfg.hold_first_ms};
    assign over_repeat = elapsed > {{(bchd_pkg::TIME_W-bchd_pkg::THR_W){1'b0}},
                                    cfg.hold_repeat_ms};

    always_comb begin
        event_res        = bchd_pkg::EV_NONE;
        mark_time_next   = mark_time_reg;
        repeating_next   = repeating_reg;
        was_pressed_next = pressed;
        priority if (pressed && !was_pressed_reg) begin
            mark_time_next = now_ms;
            repeating_next = 1'b0;
        end else if (was_pressed_reg) begin
            priority if (!pressed && over_click && !repeating_reg) begin
                event_res = bchd_pkg::EV_CLICK;
            end else if (!repeating_reg && over_first) begin
                mark_time_next = now_ms;
                repeating_next = 1'b1;
                event_res      = bchd_pkg::EV_HOLD;
            end else if (repeating_reg && over_repeat) begin
                mark_time_next = now_ms;
                event_res      = bchd_pkg::EV_HOLD;
            end else begin
                event_res = bchd_pkg::EV_NONE;
            end
        end else begin
            event_res = bchd_pkg::EV_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            was_pressed_reg <= 1'b0;
            repeating_reg   <= 1'b0;
            mark_time_reg   <= '0;
        end else if (step_en) begin
            was_pressed_reg <= was_pressed_next;
            repeating_reg   <= repeating_next;
            mark_time_reg   <= mark_time_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/button_click_hold_detector.sv =====
// an accepted word passes the input register, then the result register that drives m_tdata
// throughput: one word per cycle while m_tready stays high; the single state update per word sets that
// an empty input register takes a new word while a result still waits;
// m_tready low with both stages full drops s_tready in the same cycle
// reset (aresetn low, synchronous): thresholds to 200/1500/1000 ms, tracking
// state cleared, both pipeline stages empty
`default_nettype none
// ----------------------------------------------------------------------------
// button_click_hold_detector
// classifies polled button samples into click, hold and repeated hold events
// ----------------------------------------------------------------------------
module button_click_hold_detector (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // input stream
    input  wire logic                            s_tvalid,
    output      logic                            s_tready,
    // [0] pin_level, [32:1] now_ms, [39:33] zero
    input  wire logic [bchd_pkg::S_TDATA_W-1:0]  s_tdata,
    // result stream
    output      logic                            m_tvalid,
    input  wire logic                            m_tready,
    // [1:0] event_res, [7:2] zero
    output      logic [bchd_pkg::M_TDATA_W-1:0]  m_tdata,
    // threshold write port
    input  wire logic                            cfg_wr_en,
    input  wire logic [bchd_pkg::IDX_W-1:0]      cfg_index,
    input  wire logic [bchd_pkg::THR_W-1:0]      cfg_wdata
);

    // input register stage
    logic                        in_valid_reg;
    logic                        pin_reg;
    logic [bchd_pkg::TIME_W-1:0] now_reg;

    // result register stage
    logic                        out_valid_reg;
    bchd_pkg::event_t            out_event_reg;

    bchd_pkg::cfg_t              cfg;
    bchd_pkg::event_t            core_event;
    logic                        advance;
    logic                        s_accept;

    // a word moves into the result register when the slot is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    // payload holds no reset
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            pin_reg <= s_tdata[0];
            now_reg <= s_tdata[bchd_pkg::TIME_W:1];
        end
    end

    bchd_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // state advances exactly once per word, when it enters the result stage
    bchd_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (advance),
        .pin_level (pin_reg),
        .now_ms    (now_reg),
        .cfg       (cfg),
        .event_res (core_event)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_event_reg <= core_event;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(bchd_pkg::M_TDATA_W-bchd_pkg::EVT_W){1'b0}}, out_event_reg};

endmodule
`default_nettype wire

// ===== sim/button_click_hold_detector_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// button_click_hold_detector_tb
// self-checking bench: a directed table of polls and threshold writes, then
// random press / hold / release gestures under several idle and stall phases;
// every result word is compared with the table's event or an in-bench classifier of the polls
// ----------------------------------------------------------------------------
module button_click_hold_detector_tb;

    // no index 3 register, writes there must leave the thresholds alone
    localparam logic [bchd_pkg::IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam int DIR_ROWS     = 28;
    localparam int SEGMENTS     = 8;
    localparam int SEG_WORDS    = 50;
    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_LIMIT  = 4000;

    typedef logic [bchd_pkg::TIME_W-1:0] stamp_t;
    typedef logic [bchd_pkg::THR_W-1:0]  thr_t;

    typedef enum logic {
        ROW_WORD,
        ROW_CFG
    } row_kind_t;

    // one line of the directed table; typed_ev is used only where typed is set
    typedef struct packed {
        row_kind_t                   kind;
        logic                        pin;
        stamp_t                      now_ms;
        logic [bchd_pkg::IDX_W-1:0]  idx;
        thr_t                        val;
        logic                        typed;
        bchd_pkg::event_t            typed_ev;
    } stim_row_t;

    // dut ports, the inputs all driven from time zero
    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    // [0] pin_level, [32:1] now_ms, [39:33] zero
    logic [bchd_pkg::S_TDATA_W-1:0] s_tdata   = '0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    // [1:0] event_res, [7:2] zero
    logic [bchd_pkg::M_TDATA_W-1:0] m_tdata;
    logic                           cfg_wr_en = 1'b0;
    logic [bchd_pkg::IDX_W-1:0]     cfg_index = '0;
    thr_t                           cfg_wdata = '0;

    // classifier copy of the thresholds and the tracking state
    thr_t   thr_click     = bchd_pkg::CLICK_MIN_RST;
    thr_t   thr_first     = bchd_pkg::HOLD_FIRST_RST;
    thr_t   thr_repeat    = bchd_pkg::HOLD_REPEAT_RST;
    logic   btn_pressed   = 1'b0;
    stamp_t btn_mark      = '0;
    logic   btn_repeating = 1'b0;

    bchd_pkg::event_t pending_events [$];
    int     mismatches     = 0;
    int     results_seen   = 0;
    int     words_sent     = 0;
    int     send_idle_pct  = 0;
    int     recv_stall_pct = 0;
    stamp_t walk_ms = '0;

    // directed table, rows run against the reset thresholds until written
    stim_row_t dir_rows [0:DIR_ROWS-1] = '{
        // idle polls right after reset, both time extremes
        '{ROW_WORD, 1'b1, 32'h0000_0000, bchd_pkg::REG_CLICK_MIN, 16'h0000, 1'b1, bchd_pkg::EV_NONE},
        '{ROW_WORD, 1'b1, 32'hFFFF_FFFF, bchd_pkg::REG_CLICK_MIN, 16'h0000, 1'b1, bchd_pkg::EV_NONE},
        // press, then release exactly at the click minimum: no click
        '{ROW_WORD, 1'b0, 32'd1000, bchd_pkg::REG_CLICK_MIN, 16'h0000, 1'b0, bchd_pkg::EV_NONE},
        '{ROW_WORD, 1'b0, 32'd1100, bchd_pkg::REG_CLICK_MIN, 16'h0000, 1'b0, bchd_pkg::EV_NONE},
        '{ROW_WORD, 1'b1, 32'd1200, bchd_pkg::REG_CLICK_MIN, 16'h0000, 1'b1, bchd_pkg::EV_NONE},
        // one past the click minimum
        '{ROW_WORD, 1'b0, 32'd2000, bchd_pkg::REG_CLICK_MIN, 16'h0000, 1'b0, bchd_pkg::EV_NONE},
        '{ROW_WORD, 1'b1, 32'd2201, bchd_pkg::REG_CLICK_MIN, 16'h0000, 1'b0, bchd_pkg::EV_NONE},
        // first hold at the boundary, then a repeat at its boundary
        '{ROW_WORD, 1'b0, 32'd3000, bchd_pkg::REG_CLICK_MIN, 16'h0000, 1'b0, bchd_pkg::EV_NONE},
        '{ROW_WORD, 1'b0, 32'd4500, bchd_pkg::REG_CLICK_MIN, 16'h0000, 1'b0, bchd_pkg::EV_NONE},
        '{ROW_WORD, 1'b0, 32'd4501, bchd_pkg::REG_CLICK_MIN, 16'h0000, 1'b0, bchd_pkg::EV_NONE},
        '{ROW_WORD, 1'b0, 32'd5501, bchd_pkg::REG_CLICK_MIN, 16'h0000, 1'b0, bchd_pkg::EV_NONE},
        '{ROW_WORD, 1'b0, 32'd5502, bchd_pkg::REG_CLICK_MIN, 16'h0000, 1'b0, bchd_pkg::EV_NONE},
        // release while repeating still fires the repeat hold
        '{ROW_WORD, 1'b1, 32'd6503, bchd_pkg::REG_CLICK_MIN, 16'h0000, 1'b0, bchd_pkg::EV_NONE},
        '{ROW_WORD, 1'b1, 32'd9000, bchd_pkg::REG_CLICK_MIN, 16'h0000, 1'b0, bchd_pkg::EV_NONE},
        // click across the wrap of the timestamp
        '{ROW_WORD, 1'b0, 32'hFFFF_FF00, bchd_pkg::REG_CLICK_MIN, 16'h0000, 1'b0, bchd_pkg::EV_NONE},
        '{ROW_WORD, 1'b1, 32'h0000_0010, bchd_pkg::REG_CLICK_MIN, 16'h0000, 1'b0, bchd_pkg::EV_NONE},
        // timestamp stepping backwards looks like a huge hold time
        '{ROW_WORD, 1'b0, 32'd100, bchd_pkg::REG_CLICK_MIN, 16'h0000, 1'b0, bchd_pkg::EV_NONE},
        '{ROW_WORD, 1'b0, 32'd50,  bchd_pkg::REG_CLICK_MIN, 16'h0000, 1'b1, bchd_pkg::EV_HOLD},
        '{ROW_WORD, 1'b0, 32'd49,  bchd_pkg::REG_CLICK_MIN, 16'h0000, 1'b0, bchd_pkg::EV_NONE},
        '{ROW_WORD, 1'b1, 32'd49,  bchd_pkg::REG_CLICK_MIN, 16'h0000, 1'b0, bchd_pkg::EV_NONE},
        // click minimum above first hold: a release turns into a hold
        '{ROW_CFG, 1'b0, 32'd0, bchd_pkg::REG_CLICK_MIN,  16'hFFFF, 1'b0, bchd_pkg::EV_NONE},
        '{ROW_CFG, 1'b0, 32'd0, bchd_pkg::REG_HOLD_FIRST, 16'h0000, 1'b0, bchd_pkg::EV_NONE},
        '{ROW_CFG, 1'b0, 32'd0, REG_UNUSED,               16'h1234, 1'b0, bchd_pkg::EV_NONE},
        '{ROW_WORD, 1'b0, 32'h8000_0000, bchd_pkg::REG_CLICK_MIN, 16'h0000, 1'b0, bchd_pkg::EV_NONE},
        '{ROW_WORD, 1'b1, 32'h8000_0001, bchd_pkg::REG_CLICK_MIN, 16'h0000, 1'b1, bchd_pkg::EV_HOLD},
        // zero elapsed with a zero first hold: strict compare, no hold
        '{ROW_CFG, 1'b0, 32'd0, bchd_pkg::REG_HOLD_REPEAT, 16'hFFFF, 1'b0, bchd_pkg::EV_NONE},
        '{ROW_WORD, 1'b0, 32'h8000_0001, bchd_pkg::REG_CLICK_MIN, 16'h0000, 1'b0, bchd_pkg::EV_NONE},
        '{ROW_WORD, 1'b0, 32'h8000_0001, bchd_pkg::REG_CLICK_MIN, 16'h0000, 1'b0, bchd_pkg::EV_NONE}
    };

    button_click_hold_detector i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // classify one poll and advance the tracking state
    function automatic bchd_pkg::event_t classify_poll(input logic pin, input stamp_t now);
        logic             pressed;
        stamp_t           elapsed;
        bchd_pkg::event_t ev;
        pressed = ~pin;
        elapsed = now - btn_mark;
        ev      = bchd_pkg::EV_NONE;
        if (pressed && !btn_pressed) begin
            // press edge restarts the timing
            btn_mark      = now;
            btn_repeating = 1'b0;
        end else if (btn_pressed) begin
            if (!pressed && !btn_repeating && elapsed > stamp_t'(thr_click)) begin
                ev = bchd_pkg::EV_CLICK;
            end else if (!btn_repeating && elapsed > stamp_t'(thr_first)) begin
                btn_mark      = now;
                btn_repeating = 1'b1;
                ev            = bchd_pkg::EV_HOLD;
            end else if (btn_repeating && elapsed > stamp_t'(thr_repeat)) begin
                btn_mark = now;
                ev       = bchd_pkg::EV_HOLD;
            end
        end
        btn_pressed = pressed;
        return ev;
    endfunction

    // time step between polls, mostly small or right around a threshold
    function automatic stamp_t next_step();
        stamp_t thr;
        case ($urandom_range(9))
            0, 1, 2: return $urandom_range(0, 50);
            3, 4:    thr = stamp_t'(thr_click);
            5, 6:    thr = stamp_t'(thr_first);
            7, 8:    thr = stamp_t'(thr_repeat);
            default: return $urandom;
        endcase
        return thr + $urandom_range(0, 2) - 1;
    endfunction

    function automatic thr_t pick_thr();
        case ($urandom_range(3))
            0:       return '0;
            1:       return '1;
            2:       return thr_t'($urandom_range(0, 2000));
            default: return thr_t'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        mismatches++;
    endtask

    // present one poll word, with random sender idling, and wait for its accept
    task automatic send_word(input logic pin, input stamp_t now,
                             input logic typed, input bchd_pkg::event_t typed_ev);
        logic [bchd_pkg::S_TDATA_W-1:0] word;
        bchd_pkg::event_t               ev;
        word                   = '0;
        word[0]                = pin;
        word[bchd_pkg::TIME_W:1] = now;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        // accepted at this edge
        ev = classify_poll(pin, now);
        pending_events.push_back(typed ? typed_ev : ev);
        words_sent++;
    endtask

    // stop sending and let every outstanding result come out
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_events.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // single register write, the enable is dropped on the following cycle
    task automatic write_reg(input logic [bchd_pkg::IDX_W-1:0] idx, input thr_t val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            bchd_pkg::REG_CLICK_MIN:   thr_click  = val;
            bchd_pkg::REG_HOLD_FIRST:  thr_first  = val;
            bchd_pkg::REG_HOLD_REPEAT: thr_repeat = val;
            default:                   ;
        endcase
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // result side: check each accepted word, then pick the next ready
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_events.size() == 0) begin
                report_mismatch($sformatf("result word %h with nothing pending", m_tdata));
            end else begin
                bchd_pkg::event_t want;
                want = pending_events.pop_front();
                if (m_tdata[bchd_pkg::EVT_W-1:0] !== want) begin
                    report_mismatch($sformatf("result %0d: event_res %0d, predicted %0d",
                                              results_seen, m_tdata[bchd_pkg::EVT_W-1:0],
                                              want));
                end
            end
            results_seen++;
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog on cycles without any transfer
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin : stimulus
        thr_t c_val;
        thr_t f_val;
        thr_t r_val;
        int   target;
        int   held;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table
        for (int r = 0; r < DIR_ROWS; r++) begin
            if (dir_rows[r].kind == ROW_CFG) begin
                drain();
                write_reg(dir_rows[r].idx, dir_rows[r].val);
            end else begin
                send_word(dir_rows[r].pin, dir_rows[r].now_ms,
                          dir_rows[r].typed, dir_rows[r].typed_ev);
            end
        end

        // random gestures, two threshold settings per idle phase
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            drain();
            case (seg)
                0: begin
                    c_val = bchd_pkg::CLICK_MIN_RST;
                    f_val = bchd_pkg::HOLD_FIRST_RST;
                    r_val = bchd_pkg::HOLD_REPEAT_RST;
                end
                1: begin
                    c_val = '0;
                    f_val = '0;
                    r_val = '0;
                end
                2: begin
                    c_val = '1;
                    f_val = '1;
                    r_val = '1;
                end
                default: begin
                    c_val = pick_thr();
                    f_val = pick_thr();
                    r_val = pick_thr();
                end
            endcase
            write_reg(bchd_pkg::REG_CLICK_MIN, c_val);
            write_reg(bchd_pkg::REG_HOLD_FIRST, f_val);
            write_reg(bchd_pkg::REG_HOLD_REPEAT, r_val);
            if (seg == 3) begin
                write_reg(REG_UNUSED, thr_t'($urandom));
            end

            case (seg / 2)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase

            walk_ms = $urandom;
            target  = words_sent + SEG_WORDS;
            while (words_sent < target) begin
                if ($urandom_range(9) == 0) begin
                    // noise: random pin levels at random times
                    repeat ($urandom_range(1, 4)) begin
                        send_word($urandom_range(1) == 1, $urandom, 1'b0, bchd_pkg::EV_NONE);
                    end
                end else begin
                    // press, a few held polls with rare bounces, release, idle tail
                    walk_ms += next_step();
                    send_word(1'b0, walk_ms, 1'b0, bchd_pkg::EV_NONE);
                    held = $urandom_range(0, 6);
                    repeat (held) begin
                        walk_ms += next_step();
                        send_word($urandom_range(19) == 0, walk_ms, 1'b0, bchd_pkg::EV_NONE);
                    end
                    walk_ms += next_step();
                    send_word(1'b1, walk_ms, 1'b0, bchd_pkg::EV_NONE);
                    repeat ($urandom_range(0, 2)) begin
                        walk_ms += next_step();
                        send_word(1'b1, walk_ms, 1'b0, bchd_pkg::EV_NONE);
                    end
                end
            end
        end

        drain();
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire
